// ----- sv/isort_pkg.sv -----
package isort_pkg;

  localparam int unsigned Depth = 16;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isort_state_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } isort_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               overflow;
  } isort_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic               insert;
    logic               drain;
    logic signed [31:0] value;
  } isort_ctrl_t;

endpackage

// ----- sv/isort_cell.sv -----
module isort_cell
  import isort_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isort_ctrl_t        ctrl_i,
  input  logic signed [31:0] prev_value_i,
  input  logic               prev_valid_i,
  input  logic               prev_greater_i,
  input  logic signed [31:0] next_value_i,
  input  logic               next_valid_i,
  output logic signed [31:0] value_o,
  output logic               valid_o,
  output logic               greater_o
);

  logic signed [31:0] value_d, value_q;
  logic               valid_d, valid_q;

  // an empty cell counts as larger than any value
  assign greater_o = !valid_q || (value_q > ctrl_i.value);
  assign value_o   = value_q;
  assign valid_o   = valid_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (prev_greater_i) begin
        // lower neighbour moves up
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else if (greater_o) begin
        // insertion point
        value_d = ctrl_i.value;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drain) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- sv/insertion_sort_engine_core.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o   | isort_in_t  (value, last)
// out     | output    | out_valid_o/out_stall_i | isort_out_t (sorted_value, final_res, overflow)
//
// a value is written into the cell chain registers when it is taken; values may follow back to back
// a transaction marked last is inserted if there is room, then the set leaves one value
// per cycle from the bottom cell while the output is not stalled; input is stalled
// during the drain
// reset clears the cell occupancy, the drop flag, the state and the output valid flag
// output stall simply freezes the drain; the output register holds its transaction
module insertion_sort_engine_core
  import isort_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  isort_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output isort_out_t out_data_o
);

  isort_state_e state_d, state_q;

  // chain taps
  logic signed [31:0] cell_value   [Depth];
  logic               cell_valid   [Depth];
  logic               cell_greater [Depth];

  isort_ctrl_t ctrl;
  logic        in_take;
  logic        full;
  logic        load;
  logic        dropped_d, dropped_q;
  isort_out_t  out_d, out_q;
  logic        out_valid_d, out_valid_q;

  assign full    = cell_valid[Depth-1];
  assign in_take = in_valid_i && !in_stall_o;

  // insert only while there is room; otherwise the value is dropped
  assign ctrl.insert = in_take && !full;
  assign ctrl.drain  = load;
  assign ctrl.value  = in_data_i.value;

  // row of compare-and-shift cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [31:0] prev_value;
    logic               prev_valid;
    logic               prev_greater;
    logic signed [31:0] next_value;
    logic               next_valid;

    if (i == 0) begin : g_bottom
      assign prev_value   = '0;
      assign prev_valid   = 1'b0;
      assign prev_greater = 1'b0;
    end else begin : g_mid_lo
      assign prev_value   = cell_value[i-1];
      assign prev_valid   = cell_valid[i-1];
      assign prev_greater = cell_greater[i-1];
    end

    if (i == Depth - 1) begin : g_top
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_hi
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_value_i  (prev_value),
      .prev_valid_i  (prev_valid),
      .prev_greater_i(prev_greater),
      .next_value_i  (next_value),
      .next_valid_i  (next_valid),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .greater_o     (cell_greater[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (in_take && in_data_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // bottom cell holds the final value once the one above is empty
        if (load && !cell_valid[1]) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    case (state_q)
      ST_FILL: begin
        in_stall_o = 1'b0;
      end
      ST_DRAIN: begin
        load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // drop flag lives for one set
  always_comb begin
    dropped_d = dropped_q;
    if (in_take && full) begin
      dropped_d = 1'b1;
    end else if (load && !cell_valid[1]) begin
      dropped_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_d.sorted_value = cell_value[0];
      out_d.final_res    = !cell_valid[1];
      out_d.overflow     = dropped_q;
      out_valid_d        = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/isort_checker.sv -----
`timescale 1ns / 100ps

module isort_checker
  import isort_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  isort_in_t   in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  isort_out_t  out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // own copy of the sorted set being built
  logic signed [31:0] ranked_vals [Depth];
  int unsigned        ranked_cnt;
  bit                 set_dropped;

  // ascending results still to come out of the block
  isort_out_t         ascending_q [$];

  task automatic insert_ranked(input isort_in_t item);
    int unsigned pos;
    int unsigned k;
    isort_out_t  res;
    if (ranked_cnt < Depth) begin
      pos = ranked_cnt;
      // larger entries move up, equal ones stay below the newcomer
      while (pos > 0 && $signed(ranked_vals[pos-1]) > $signed(item.value)) begin
        ranked_vals[pos] = ranked_vals[pos-1];
        pos--;
      end
      ranked_vals[pos] = item.value;
      ranked_cnt++;
    end else begin
      set_dropped = 1'b1;
    end
    if (item.last) begin
      for (k = 0; k < ranked_cnt; k++) begin
        res.sorted_value = ranked_vals[k];
        res.final_res    = (k + 1 == ranked_cnt);
        res.overflow     = set_dropped;
        ascending_q.push_back(res);
      end
      ranked_cnt  = 0;
      set_dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    isort_out_t want;
    if (!rst_ni) begin
      ranked_cnt   = 0;
      set_dropped  = 1'b0;
      ascending_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first, so a transaction never meets its own expectation
      if (out_valid_i && !out_stall_i) begin
        if (ascending_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d", $signed(out_data_i.sorted_value));
          fail_count_o++;
        end else begin
          want = ascending_q.pop_front();
          if (out_data_i.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", $signed(want.sorted_value),
                   $signed(out_data_i.sorted_value));
            fail_count_o++;
          end
          if (out_data_i.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, out_data_i.final_res);
            fail_count_o++;
          end
          if (out_data_i.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data_i.overflow);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        insert_ranked(in_data_i);
      end
      pending_o = ascending_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import isort_pkg::*;

  // generous bound: 270 transactions, each with a long gap, a full drain and long stalls
  localparam int unsigned CycleLimit = 1_000_000;
  // drain of a full set plus the longest output stall
  localparam int unsigned EndWait    = 64;
  localparam int unsigned ItemTarget = 270;

  localparam logic signed [31:0] MinVal = 32'sh8000_0000;
  localparam logic signed [31:0] MaxVal = 32'sh7fff_ffff;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  isort_in_t   in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  isort_out_t  out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_run   = 0;
  int unsigned sent        = 0;
  // registered handshake, read at the falling edge free of races
  logic        in_taken;
  // set per transaction group: no gaps and no stalls for a while
  logic        steady      = 1'b0;

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  insertion_sort_engine_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  isort_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // remember whether the input transaction went through at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // run lengths for the output stall: mostly short, now and then long
  function automatic int unsigned pick_run();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 14) return $urandom_range(0, 3);
    if (r == 14) return $urandom_range(5, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver back-pressure, changed at the falling edge only
  always @(negedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= pick_run();
    end
  end

  // sender gap before a transaction
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    if (r == 18) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // extremes, a narrow band around zero for ties, and full-width noise
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = MinVal;
      1:       v = MaxVal;
      2, 3:    v = 32'($urandom_range(0, 8)) - 32'd4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one transaction and hold it until the block takes it;
  // returns at the falling edge just after acceptance
  task automatic send_value(input logic signed [31:0] v, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.value     <= v;
    in_data_i.last      <= is_last;
    do @(negedge clk_i); while (!in_taken);
    sent++;
  endtask

  // sender holds off until every result of earlier sets has left the block
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int unsigned set_len;
    int unsigned r;
    int unsigned k;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-value sets at both ends of the range
    send_value(MinVal, 1'b1);
    send_value(MaxVal, 1'b1);

    // mixed signs, extremes and a tie within one set
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(MaxVal, 1'b0);
    send_value(32'sd7, 1'b0);
    send_value(MinVal, 1'b0);
    send_value(32'sd7, 1'b1);

    // descending run that fills the store, the closing transaction is dropped
    for (k = 0; k <= Depth; k++) begin
      send_value(32'sd40 - 32'(5 * k), k == Depth);
    end

    drain_wait();

    // random sets: mostly short, some full, a few past the store size
    while (sent < ItemTarget) begin
      steady <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 12) set_len = $urandom_range(1, 6);
      else if (r < 16) set_len = $urandom_range(7, 15);
      else if (r < 18) set_len = Depth;
      else set_len = $urandom_range(Depth + 1, Depth + 6);
      for (k = 1; k <= set_len; k++) begin
        send_value(pick_value(), k == set_len);
      end
      if ($urandom_range(0, 5) == 0) begin
        drain_wait();
      end
    end

    in_valid_i <= 1'b0;
    steady     <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    // catch any stray result after the last expected one
    repeat (EndWait) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/isort_pkg.sv
sv/isort_cell.sv
sv/insertion_sort_engine_core.sv
tb/isort_checker.sv
tb/tb_top.sv
